@@ rtl/pcrl_pkg.sv @@
// Shared types, codes and helpers of the per-client rate limiter.
`default_nettype none
package pcrl_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [DATA_W-1:0] CNT_MAX = '1;

    // Action codes
    localparam logic [1:0] ACT_NEW    = 2'd0;
    localparam logic [1:0] ACT_CLOSE  = 2'd1;
    localparam logic [1:0] ACT_REQ    = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Verdicts
    localparam logic VERDICT_PASS  = 1'b0;
    localparam logic VERDICT_BLOCK = 1'b1;

    // Cause codes
    localparam logic [2:0] CAUSE_NONE       = 3'd0;
    localparam logic [2:0] CAUSE_TABLE_FULL = 3'd1;
    localparam logic [2:0] CAUSE_CONCURRENT = 3'd2;
    localparam logic [2:0] CAUSE_CONN_BURST = 3'd3;
    localparam logic [2:0] CAUSE_CONN_RATE  = 3'd4;
    localparam logic [2:0] CAUSE_REQ_BURST  = 3'd5;
    localparam logic [2:0] CAUSE_REQ_RATE   = 3'd6;
    localparam logic [2:0] CAUSE_BAD_CLOSE  = 3'd7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_BURST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONN_RATE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONN_BURST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONCURRENT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE       = 3'd5;
    localparam int unsigned          CFG_NUM        = 6;

    localparam logic [DATA_W-1:0] IDLE_RESET = 32'd14400;

    typedef struct packed {
        logic [1:0]        action;
        logic [63:0]       client_high;
        logic [63:0]       client_low;
        logic [DATA_W-1:0] now_tick;
    } t_in_item;

    typedef struct packed {
        logic       verdict;
        logic [2:0] cause;
    } t_out_item;

    typedef struct packed {
        logic [63:0]       addr_high;
        logic [63:0]       addr_low;
        logic [DATA_W-1:0] last_seen;
        logic [DATA_W-1:0] live_conns;
    } t_entry;

    typedef struct packed {
        logic [DATA_W-1:0] stamp;
        logic [DATA_W-1:0] new_conns;
        logic [DATA_W-1:0] requests;
    } t_slot;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_CLEAR,
        S_ENTRY,
        S_SLOT_RD,
        S_SUM,
        S_CHECK,
        S_DONE
    } t_state;

    function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage
`default_nettype wire

@@ rtl/pcrl_mod_unit.sv @@
// Remainder of a 32-bit tick by the slot count, by reciprocal multiplication.
`default_nettype none
module pcrl_mod_unit
    import pcrl_pkg::*;
#(
    parameter int unsigned SLOTS = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [DATA_W-1:0]            i_dividend,
    output logic                              o_done,
    output logic [$clog2(SLOTS)-1:0]          o_rem
);
    localparam int unsigned MW = $clog2(SLOTS);
    localparam int unsigned PW = 2 * DATA_W;
    // floor(2^32 / SLOTS): the quotient estimate is exact or one short
    localparam logic [PW-1:0]     RECIP_W = (PW'(1) << DATA_W) / PW'(SLOTS);
    localparam logic [DATA_W-1:0] RECIP   = RECIP_W[DATA_W-1:0];
    localparam logic [DATA_W-1:0] DIVISOR = DATA_W'(SLOTS);

    logic              r_busy;
    logic              r_done;
    logic [1:0]        r_step;
    logic [DATA_W-1:0] r_x;
    logic [PW-1:0]     r_prod;
    logic [DATA_W-1:0] r_est;
    logic [MW-1:0]     r_rem;
    logic [DATA_W-1:0] n_quot;
    logic [DATA_W-1:0] n_fix;

    // Quotient estimate, then one conditional subtract of the divisor
    always_comb begin
        n_quot = r_prod[PW-1:DATA_W];
        n_fix  = (r_est >= DIVISOR) ? (r_est - DIVISOR) : r_est;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
            r_x    <= i_dividend;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            case (r_step)
                2'd0: begin
                    r_prod <= PW'(r_x) * PW'(RECIP);
                end
                2'd1: begin
                    r_est <= r_x - n_quot * DIVISOR;
                end
                default: begin
                    r_rem  <= n_fix[MW-1:0];
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

@@ rtl/per_client_rate_limiter.sv @@
// Top level of the per-client sliding-window rate limiter.
`default_nettype none
// Per-client rate limiter. Each item is one event (new connection, close or
// request) for a 128-bit client address at a tick time; each item yields one
// result item with a pass/block verdict and a cause code. Accounts live in a
// table of ACCOUNTS entries with one read and one write port; slot counters
// live in a second table of ACCOUNTS*SLOTS rows. An item is handled one at a
// time: the account table is swept one entry per cycle (match, idle freeing
// and free slot search in one pass), an account that is new has its SLOTS
// slot rows zeroed one per cycle, and the window sum reads the SLOTS rows one
// per cycle. A close of a known account finishes after the sweep through the
// decide and entry states, any other close and a blocked allocation through
// the decide state alone, and unused action codes go straight from acceptance
// to the done state. The result sits in an output register, so the next item
// is taken while a result still waits on a stalled sink; the next result then
// holds in its final state until the sink takes the waiting one. No clearing
// pass after reset is needed: account valid bits clear at reset and slot rows
// are zeroed on allocation. Configuration must be written only while idle;
// the user is bound to this, as the block itself does not enforce it.
module per_client_rate_limiter
    import pcrl_pkg::*;
#(
    parameter int unsigned ACCOUNTS = 64,
    parameter int unsigned SLOTS    = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [DATA_W-1:0]    i_cfg_data
);
    localparam int unsigned AW   = (ACCOUNTS > 1) ? $clog2(ACCOUNTS) : 1;
    localparam int unsigned CW   = $clog2(ACCOUNTS + 1);
    localparam int unsigned MW   = $clog2(SLOTS);
    localparam int unsigned SCW  = $clog2(SLOTS + 1);
    localparam int unsigned SIW  = $clog2(ACCOUNTS * SLOTS);
    localparam int unsigned SUMW = DATA_W + $clog2(SLOTS);

    // Configuration registers
    logic [DATA_W-1:0] r_cfg [CFG_NUM];

    // Memories
    t_entry mem_entry [ACCOUNTS];
    t_slot  mem_slot  [ACCOUNTS*SLOTS];
    t_entry r_entry_rd;
    t_slot  r_slot_rd;

    // Control and datapath registers
    t_state            r_state, n_state;
    t_in_item          r_item;
    logic [ACCOUNTS-1:0] r_valid;
    logic [CW-1:0]     r_cnt;
    logic              r_pv;
    logic [AW-1:0]     r_pidx;
    logic              r_hit_found;
    logic [AW-1:0]     r_hit_idx;
    logic              r_free_found;
    logic [AW-1:0]     r_free_idx;
    logic [AW-1:0]     r_idx;
    logic [SIW-1:0]    r_base;
    logic [DATA_W-1:0] r_live;
    logic [SCW-1:0]    r_scnt;
    logic              r_spv;
    logic [SUMW-1:0]   r_sum;
    logic              r_conc_bad;
    logic              r_burst_bad;
    t_out_item         r_res;
    logic              r_out_valid;
    t_out_item         r_out;

    // Memory controls
    logic              ent_we;
    logic [AW-1:0]     ent_waddr;
    t_entry            ent_wdata;
    logic [AW-1:0]     ent_raddr;
    logic              slot_we;
    logic [SIW-1:0]    slot_waddr;
    t_slot             slot_wdata;
    logic [SIW-1:0]    slot_raddr;

    // Remainder unit
    logic              mod_start;
    logic              mod_done;
    logic [MW-1:0]     mod_rem;

    // Scan evaluation
    logic              in_acc;
    logic              sc_v, sc_match, sc_stale, sc_free;
    logic [DATA_W-1:0] sc_age;
    logic              scan_end;
    logic              sum_end;
    logic              out_free;

    // Slot update
    logic              slot_fresh;
    logic [DATA_W-1:0] upd_nc, upd_rq, upd_live;
    logic [DATA_W-1:0] win_age;
    logic [DATA_W-1:0] win_cnt;
    logic [DATA_W-1:0] lim_rate;

    pcrl_mod_unit #(
        .SLOTS(SLOTS)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (i_in_data.now_tick),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // Evaluate the account read back during the sweep
    always_comb begin
        sc_v     = r_valid[r_pidx];
        sc_match = sc_v && (r_entry_rd.addr_high == r_item.client_high)
                        && (r_entry_rd.addr_low == r_item.client_low);
        sc_age   = r_item.now_tick - r_entry_rd.last_seen;
        sc_stale = sc_v && !sc_match && (sc_age > r_cfg[CFG_IDLE]);
        sc_free  = !sc_v || sc_stale;
    end

    assign scan_end = (r_cnt == CW'(ACCOUNTS)) && !r_pv && mod_done;
    assign sum_end  = (r_scnt == SCW'(SLOTS)) && !r_spv;

    // Current slot after restamping, and the incremented counts
    always_comb begin
        slot_fresh = (r_slot_rd.stamp == r_item.now_tick);
        upd_nc     = slot_fresh ? r_slot_rd.new_conns : '0;
        upd_rq     = slot_fresh ? r_slot_rd.requests  : '0;
        upd_live   = r_live;
        if (r_item.action == ACT_NEW) begin
            upd_nc   = sat_inc(upd_nc);
            upd_live = sat_inc(r_live);
        end else begin
            upd_rq = sat_inc(upd_rq);
        end
    end

    // Window membership of the slot row being summed
    always_comb begin
        win_age  = r_item.now_tick - r_slot_rd.stamp;
        win_cnt  = (r_item.action == ACT_NEW) ? r_slot_rd.new_conns
                                              : r_slot_rd.requests;
        lim_rate = (r_item.action == ACT_NEW) ? r_cfg[CFG_CONN_RATE]
                                              : r_cfg[CFG_REQ_RATE];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.action == ACT_UNUSED) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_hit_found) begin
                    n_state = S_ENTRY;
                end else if (r_item.action == ACT_CLOSE || !r_free_found) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                if (r_scnt == SCW'(SLOTS - 1)) begin
                    n_state = S_ENTRY;
                end
            end
            S_ENTRY: begin
                if (r_item.action == ACT_CLOSE) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SLOT_RD;
                end
            end
            S_SLOT_RD: n_state = S_SUM;
            S_SUM: begin
                if (sum_end) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory and unit controls
    always_comb begin
        mod_start  = 1'b0;
        ent_we     = 1'b0;
        ent_waddr  = r_idx;
        ent_wdata  = '{addr_high:  r_item.client_high,
                       addr_low:   r_item.client_low,
                       last_seen:  r_item.now_tick,
                       live_conns: r_live};
        ent_raddr  = '0;
        slot_we    = 1'b0;
        slot_waddr = r_base + SIW'(r_scnt);
        slot_wdata = '0;
        slot_raddr = r_base;
        case (r_state)
            S_IDLE: begin
                mod_start = in_acc && (i_in_data.action != ACT_UNUSED);
            end
            S_SCAN: begin
                ent_raddr = r_cnt[AW-1:0];
            end
            S_CLEAR: begin
                slot_we = 1'b1;
            end
            S_ENTRY: begin
                if (r_item.action == ACT_CLOSE) begin
                    ent_we = 1'b1;
                    if (r_live != '0) begin
                        ent_wdata.live_conns = r_live - 1'b1;
                    end
                end
                slot_raddr = r_base + SIW'(mod_rem);
            end
            S_SLOT_RD: begin
                ent_we               = 1'b1;
                ent_wdata.live_conns = upd_live;
                slot_we              = 1'b1;
                slot_waddr           = r_base + SIW'(mod_rem);
                slot_wdata           = '{stamp:     r_item.now_tick,
                                         new_conns: upd_nc,
                                         requests:  upd_rq};
            end
            S_SUM: begin
                if (r_scnt < SCW'(SLOTS)) begin
                    slot_raddr = r_base + SIW'(r_scnt);
                end
            end
            default: begin
            end
        endcase
    end

    // Account table
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            mem_entry[ent_waddr] <= ent_wdata;
        end
        r_entry_rd <= mem_entry[ent_raddr];
    end

    // Slot table
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            mem_slot[slot_waddr] <= slot_wdata;
        end
        r_slot_rd <= mem_slot[slot_raddr];
    end

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_NUM; i++) begin
                r_cfg[i] <= (i == int'(CFG_IDLE)) ? IDLE_RESET : '0;
            end
        end else if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(CFG_NUM))) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
            r_spv       <= 1'b0;
        end else begin
            r_state <= n_state;
            // Load a finished result, or drop the one the sink has taken
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_item       <= i_in_data;
                        r_cnt        <= '0;
                        r_pv         <= 1'b0;
                        r_hit_found  <= 1'b0;
                        r_free_found <= 1'b0;
                        r_res        <= '{verdict: VERDICT_PASS, cause: CAUSE_NONE};
                    end
                end
                S_SCAN: begin
                    // Issue the next read; evaluate the one read last cycle
                    if (r_cnt < CW'(ACCOUNTS)) begin
                        r_cnt  <= r_cnt + 1'b1;
                        r_pv   <= 1'b1;
                        r_pidx <= r_cnt[AW-1:0];
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        if (sc_match && !r_hit_found) begin
                            r_hit_found <= 1'b1;
                            r_hit_idx   <= r_pidx;
                            r_live      <= r_entry_rd.live_conns;
                        end
                        if (sc_stale) begin
                            r_valid[r_pidx] <= 1'b0;
                        end
                        if (sc_free && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_pidx;
                        end
                    end
                end
                S_DECIDE: begin
                    r_scnt <= '0;
                    if (r_hit_found) begin
                        r_idx  <= r_hit_idx;
                        r_base <= SIW'(SIW'(r_hit_idx) * SIW'(SLOTS));
                    end else if (r_item.action == ACT_CLOSE) begin
                        r_res <= '{verdict: VERDICT_BLOCK, cause: CAUSE_BAD_CLOSE};
                    end else if (!r_free_found) begin
                        r_res <= '{verdict: VERDICT_BLOCK, cause: CAUSE_TABLE_FULL};
                    end else begin
                        // Allocate the lowest free account
                        r_idx                <= r_free_idx;
                        r_base               <= SIW'(SIW'(r_free_idx) * SIW'(SLOTS));
                        r_live               <= '0;
                        r_valid[r_free_idx]  <= 1'b1;
                    end
                end
                S_CLEAR: begin
                    r_scnt <= r_scnt + 1'b1;
                end
                S_ENTRY: begin
                    if (r_item.action == ACT_CLOSE && r_live == '0) begin
                        r_res <= '{verdict: VERDICT_BLOCK, cause: CAUSE_BAD_CLOSE};
                    end
                end
                S_SLOT_RD: begin
                    if (r_item.action == ACT_NEW) begin
                        r_conc_bad  <= (r_cfg[CFG_CONCURRENT] != '0)
                                    && (upd_live > r_cfg[CFG_CONCURRENT]);
                        r_burst_bad <= (r_cfg[CFG_CONN_BURST] != '0)
                                    && (upd_nc > r_cfg[CFG_CONN_BURST]);
                    end else begin
                        r_conc_bad  <= 1'b0;
                        r_burst_bad <= (r_cfg[CFG_REQ_BURST] != '0)
                                    && (upd_rq > r_cfg[CFG_REQ_BURST]);
                    end
                    r_scnt <= '0;
                    r_spv  <= 1'b0;
                    r_sum  <= '0;
                end
                S_SUM: begin
                    if (r_scnt < SCW'(SLOTS)) begin
                        r_scnt <= r_scnt + 1'b1;
                        r_spv  <= 1'b1;
                    end else begin
                        r_spv <= 1'b0;
                    end
                    if (r_spv && (win_age <= DATA_W'(SLOTS))) begin
                        r_sum <= r_sum + SUMW'(win_cnt);
                    end
                end
                S_CHECK: begin
                    if (r_conc_bad) begin
                        r_res <= '{verdict: VERDICT_BLOCK, cause: CAUSE_CONCURRENT};
                    end else if (r_burst_bad) begin
                        r_res.verdict <= VERDICT_BLOCK;
                        r_res.cause   <= (r_item.action == ACT_NEW) ? CAUSE_CONN_BURST
                                                                    : CAUSE_REQ_BURST;
                    end else if ((lim_rate != '0) && (r_sum > SUMW'(lim_rate))) begin
                        r_res.verdict <= VERDICT_BLOCK;
                        r_res.cause   <= (r_item.action == ACT_NEW) ? CAUSE_CONN_RATE
                                                                    : CAUSE_REQ_RATE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out <= r_res;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

@@ bench/per_client_rate_limiter_tb.sv @@
// Self-checking testbench for the per-client rate limiter.
`default_nettype none
module per_client_rate_limiter_tb;
    import pcrl_pkg::*;

    localparam int NACC     = 64;
    localparam int NSLOT    = 8;
    localparam int CYC_LIMIT = 1000000;
    localparam int DRAIN_CYC = 120;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out_data;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DATA_W-1:0]    i_cfg_data;

    per_client_rate_limiter #(.ACCOUNTS(NACC), .SLOTS(NSLOT)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow of the limiter's limits and account table
    logic [DATA_W-1:0] lim [CFG_NUM];
    logic              acc_used  [NACC];
    logic [63:0]       acc_hi    [NACC];
    logic [63:0]       acc_lo    [NACC];
    logic [31:0]       acc_seen  [NACC];
    logic [31:0]       acc_live  [NACC];
    logic [31:0]       sl_stamp  [NACC][NSLOT];
    logic [31:0]       sl_conns  [NACC][NSLOT];
    logic [31:0]       sl_reqs   [NACC][NSLOT];

    t_out_item verdicts_due[$];
    int        errors;
    int        cycles;
    logic      idle_on;
    logic      hold_off;
    int        hold_len;
    logic [31:0] clock_tick;
    logic [63:0] pool_hi [16];
    logic [63:0] pool_lo [16];

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // Advance the shadow table by one event and return its verdict
    function automatic t_out_item judge(input t_in_item it);
        t_out_item r;
        int hit, fre, cur;
        logic [63:0] sum;
        logic [31:0] nw;
        hit = -1;
        fre = -1;
        sum = '0;
        nw  = it.now_tick;
        r.verdict = VERDICT_PASS;
        r.cause   = CAUSE_NONE;
        if (it.action == ACT_UNUSED) return r;
        for (int a = 0; a < NACC; a++) begin
            if (acc_used[a]) begin
                if (acc_hi[a] == it.client_high && acc_lo[a] == it.client_low) begin
                    if (hit < 0) hit = a;
                end else if (32'(nw - acc_seen[a]) > lim[CFG_IDLE]) begin
                    acc_used[a] = 1'b0;
                end
            end
        end
        if (hit < 0) begin
            if (it.action == ACT_CLOSE) begin
                r.verdict = VERDICT_BLOCK;
                r.cause   = CAUSE_BAD_CLOSE;
                return r;
            end
            for (int a = NACC - 1; a >= 0; a--)
                if (!acc_used[a]) fre = a;
            if (fre < 0) begin
                r.verdict = VERDICT_BLOCK;
                r.cause   = CAUSE_TABLE_FULL;
                return r;
            end
            hit = fre;
            acc_used[hit] = 1'b1;
            acc_hi[hit]   = it.client_high;
            acc_lo[hit]   = it.client_low;
            acc_live[hit] = '0;
            for (int s = 0; s < NSLOT; s++) begin
                sl_stamp[hit][s] = '0;
                sl_conns[hit][s] = '0;
                sl_reqs[hit][s]  = '0;
            end
        end
        acc_seen[hit] = nw;
        if (it.action == ACT_CLOSE) begin
            if (acc_live[hit] == 0) begin
                r.verdict = VERDICT_BLOCK;
                r.cause   = CAUSE_BAD_CLOSE;
            end else begin
                acc_live[hit] = acc_live[hit] - 1;
            end
            return r;
        end
        cur = nw % NSLOT;
        if (sl_stamp[hit][cur] != nw) begin
            sl_stamp[hit][cur] = nw;
            sl_conns[hit][cur] = '0;
            sl_reqs[hit][cur]  = '0;
        end
        if (it.action == ACT_NEW) begin
            sl_conns[hit][cur] = bump(sl_conns[hit][cur]);
            acc_live[hit]      = bump(acc_live[hit]);
            for (int s = 0; s < NSLOT; s++)
                if (32'(nw - sl_stamp[hit][s]) <= NSLOT) sum += sl_conns[hit][s];
            r.verdict = VERDICT_BLOCK;
            if (lim[CFG_CONCURRENT] != 0 && acc_live[hit] > lim[CFG_CONCURRENT])
                r.cause = CAUSE_CONCURRENT;
            else if (lim[CFG_CONN_BURST] != 0 && sl_conns[hit][cur] > lim[CFG_CONN_BURST])
                r.cause = CAUSE_CONN_BURST;
            else if (lim[CFG_CONN_RATE] != 0 && sum > lim[CFG_CONN_RATE])
                r.cause = CAUSE_CONN_RATE;
            else
                r.verdict = VERDICT_PASS;
            return r;
        end
        sl_reqs[hit][cur] = bump(sl_reqs[hit][cur]);
        for (int s = 0; s < NSLOT; s++)
            if (32'(nw - sl_stamp[hit][s]) <= NSLOT) sum += sl_reqs[hit][s];
        r.verdict = VERDICT_BLOCK;
        if (lim[CFG_REQ_BURST] != 0 && sl_reqs[hit][cur] > lim[CFG_REQ_BURST])
            r.cause = CAUSE_REQ_BURST;
        else if (lim[CFG_REQ_RATE] != 0 && sum > lim[CFG_REQ_RATE])
            r.cause = CAUSE_REQ_RATE;
        else
            r.verdict = VERDICT_PASS;
        return r;
    endfunction

    always #5 i_clk = ~i_clk;

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Sink stall: random idling, plus an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_off)
            i_out_stall <= 1'b1;
        else
            i_out_stall <= idle_on && ($urandom_range(99) < 18);
    end

    // Compare each accepted result with the oldest outstanding verdict
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_out_data);
                errors++;
            end else begin
                want = verdicts_due.pop_front();
                if (o_out_data.verdict !== want.verdict || o_out_data.cause !== want.cause) begin
                    $display("%0t: verdict/cause expected %0d/%0d actual %0d/%0d", $time,
                             want.verdict, want.cause, o_out_data.verdict, o_out_data.cause);
                    errors++;
                end
            end
        end
    end

    // Offer one item, hold it until accepted, then predict its verdict;
    // valid stays up for a following item and drops on idling or draining
    task automatic send_event(input logic [1:0] act, input logic [63:0] hi,
                              input logic [63:0] lo, input logic [31:0] tk);
        t_in_item it;
        it.action      = act;
        it.client_high = hi;
        it.client_low  = lo;
        it.now_tick    = tk;
        while (idle_on && $urandom_range(99) < 18) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        verdicts_due.push_back(judge(it));
    endtask

    // Wait for every result, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        lim[idx] = val;
    endtask

    task automatic set_limits(input logic [31:0] rr, input logic [31:0] rb,
                              input logic [31:0] cr, input logic [31:0] cb,
                              input logic [31:0] cc, input logic [31:0] il);
        drain();
        write_limit(CFG_REQ_RATE, rr);
        write_limit(CFG_REQ_BURST, rb);
        write_limit(CFG_CONN_RATE, cr);
        write_limit(CFG_CONN_BURST, cb);
        write_limit(CFG_CONCURRENT, cc);
        write_limit(CFG_IDLE, il);
        i_cfg_we <= 1'b0;
    endtask

    // Field extremes, every action and the named corner cases
    task automatic test_directed();
        set_limits(3, 2, 3, 2, 2, 40);
        send_event(ACT_UNUSED, '1, '1, '1);
        send_event(ACT_CLOSE, 64'd1, 64'd1, 32'd0);          // close of unknown client
        send_event(ACT_REQ, 64'd1, 64'd1, 32'd0);
        send_event(ACT_CLOSE, 64'd1, 64'd1, 32'd0);          // close with nothing live
        send_event(ACT_NEW, '1, '1, 32'd1);
        send_event(ACT_NEW, '1, '1, 32'd1);
        send_event(ACT_NEW, '1, '1, 32'd1);                  // concurrent
        send_event(ACT_CLOSE, '1, '1, 32'd2);
        send_event(ACT_CLOSE, '1, '1, 32'd2);
        send_event(ACT_NEW, '1, '1, 32'd2);                  // conn rate
        send_event(ACT_NEW, '1, '1, 32'd3);
        send_event(ACT_REQ, 64'd1, 64'd1, 32'd4);
        send_event(ACT_REQ, 64'd1, 64'd1, 32'd4);
        send_event(ACT_REQ, 64'd1, 64'd1, 32'd4);            // req burst
        send_event(ACT_REQ, 64'd1, 64'd1, 32'd5);            // req rate
        send_event(ACT_REQ, 64'd1, 64'd1, 32'hFFFF_FFF0);    // idle freeing, wrap
        send_event(ACT_REQ, 64'd1, 64'd1, 32'd3);            // time going backwards
        send_event(ACT_REQ, 64'h8000_0000_0000_0000, 64'd0, 32'h7FFF_FFFF);
    endtask

    // Fill the table to see table-full blocking
    task automatic test_table_full();
        set_limits(0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        for (int a = 0; a < NACC + 3; a++)
            send_event(ACT_REQ, 64'(a) << 8, 64'(a) ^ 64'hA5A5, clock_tick);
        clock_tick += 5;
    endtask

    // Sink holds off long while items keep arriving
    task automatic test_backpressure();
        drain();
        hold_len = 3000;
        fork
            begin
                hold_off <= 1'b1;
                repeat (hold_len) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            for (int k = 0; k < 12; k++)
                send_event(ACT_REQ, pool_hi[k], pool_lo[k], clock_tick);
        join
    endtask

    // Random traffic from a small client pool with mostly advancing time
    task automatic random_burst(input int n, input logic noidle);
        int p;
        logic [1:0] act;
        idle_on = !noidle;
        for (int k = 0; k < n; k++) begin
            p = $urandom_range(15);
            if ($urandom_range(99) < 60) clock_tick += $urandom_range(3);
            else if ($urandom_range(99) < 3) clock_tick += $urandom;
            case ($urandom_range(9))
                0, 1, 2, 3: act = ACT_NEW;
                4, 5:       act = ACT_CLOSE;
                9:          act = ($urandom_range(3) == 0) ? ACT_UNUSED : ACT_REQ;
                default:    act = ACT_REQ;
            endcase
            if ($urandom_range(19) == 0)
                send_event(act, {$urandom, $urandom}, {$urandom, $urandom}, clock_tick);
            else
                send_event(act, pool_hi[p], pool_lo[p], clock_tick);
        end
        idle_on = 1'b1;
    endtask

    task automatic test_random();
        set_limits(20, 4, 12, 3, 5, 64);
        random_burst(500, 1'b0);
        set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_burst(300, 1'b1);
        set_limits(1, 1, 1, 1, 1, 1);
        random_burst(300, 1'b0);
        set_limits(0, 0, 0, 0, 0, 0);
        random_burst(250, 1'b0);
        set_limits($urandom_range(40), $urandom_range(8), $urandom_range(30),
                   $urandom_range(6), $urandom_range(9), $urandom_range(200, 1));
        random_burst(500, 1'b0);
    endtask

    initial begin
        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        i_out_stall = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        errors     = 0;
        cycles     = 0;
        idle_on    = 1'b1;
        hold_off   = 1'b0;
        clock_tick = 32'd100;
        for (int a = 0; a < NACC; a++) acc_used[a] = 1'b0;
        for (int i = 0; i < CFG_NUM; i++) lim[i] = '0;
        lim[CFG_IDLE] = IDLE_RESET;
        for (int p = 0; p < 16; p++) begin
            pool_hi[p] = (p < 2) ? {64{p[0]}} : {$urandom, $urandom};
            pool_lo[p] = (p < 2) ? {64{~p[0]}} : {$urandom, $urandom};
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Default limits first: everything unlimited
        send_event(ACT_NEW, 64'd7, 64'd7, 32'd0);
        test_directed();
        test_table_full();
        test_backpressure();
        test_random();
        drain();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
